@@ design/pmd_pkg.sv @@
// shared constants, codes and helpers for the position pid motor drive
`timescale 1ns / 1ps
package pmd_pkg;

    localparam int CNT_W     = 32;
    localparam int IG_W      = 48;
    localparam int TS_W      = 32;
    localparam int GAIN_W    = 32;
    localparam int DECAY_W   = 17;
    localparam int MODE_W    = 2;
    localparam int DUTY_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(65536);
    localparam logic [31:0]        US_PER_S  = 32'd1000000;
    localparam int                 DRIVE_MAX = 255;

    // shared serial multiplier and divider widths
    localparam int MA_W  = 66;
    localparam int MB_W  = 32;
    localparam int P_W   = MA_W + MB_W;
    localparam int MC_W  = $clog2(MB_W);
    localparam int DD_W  = 32;
    localparam int DC_W  = $clog2(P_W);
    localparam int ACC_W = P_W + 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_UPDATE = 2'd0,
        MODE_TARGET = 2'd1,
        MODE_MOVE   = 2'd2,
        MODE_RESET  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP    = 2'd0,
        REG_KI    = 2'd1,
        REG_KD    = 2'd2,
        REG_DECAY = 2'd3
    } cfg_reg_t;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W:0] x);
        logic [CNT_W-1:0] r;
        if (x[CNT_W] != x[CNT_W-1])
            r = x[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        else
            r = x[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] signed_term(input logic [P_W-1:0] m,
                                                     input logic neg);
        logic [ACC_W-1:0] x;
        x = {{(ACC_W-P_W){1'b0}}, m};
        return neg ? (~x + ACC_W'(1)) : x;
    endfunction

endpackage

@@ design/pmd_if.sv @@
// request channel interfaces: input items, result items, register writes
`timescale 1ns / 1ps
interface pmd_in_if;
    logic                               valid;
    logic                               ready;
    logic [pmd_pkg::MODE_W-1:0]         mode;
    logic signed [pmd_pkg::CNT_W-1:0]   encoder_count;
    logic [pmd_pkg::TS_W-1:0]           timestamp_us;
    logic signed [pmd_pkg::CNT_W-1:0]   target_or_offset;
    modport source (output valid, mode, encoder_count, timestamp_us, target_or_offset,
                    input ready);
    modport sink (input valid, mode, encoder_count, timestamp_us, target_or_offset,
                  output ready);
endinterface

interface pmd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        dir_forward;
    logic                        dir_reverse;
    logic [pmd_pkg::DUTY_W-1:0]  pwm_duty;
    logic                        standby_release;
    logic                        motor_active;
    modport source (output valid, dir_forward, dir_reverse, pwm_duty, standby_release,
                    motor_active, input ready);
    modport sink (input valid, dir_forward, dir_reverse, pwm_duty, standby_release,
                  motor_active, output ready);
endinterface

interface pmd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pmd_pkg::CFG_IDX_W-1:0]  index;
    logic [pmd_pkg::CFG_DAT_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/pmd_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module pmd_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pmd_pkg::MA_W-1:0]  a,
    input  logic [pmd_pkg::MB_W-1:0]  b,
    output logic [pmd_pkg::P_W-1:0]   prod,
    output logic                      done
);
    logic [pmd_pkg::MA_W-1:0] a_reg;
    logic [pmd_pkg::MB_W-1:0] b_reg;
    logic [pmd_pkg::P_W-1:0]  acc_reg;
    logic [pmd_pkg::MC_W-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [pmd_pkg::MA_W:0]   sum;

    // add into the upper part, then shift right by one
    assign sum = {1'b0, acc_reg[pmd_pkg::P_W-1:pmd_pkg::MB_W]}
               + (b_reg[0] ? {1'b0, a_reg} : {(pmd_pkg::MA_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + pmd_pkg::MC_W'(1);
                if (cnt_reg == pmd_pkg::MC_W'(pmd_pkg::MB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[pmd_pkg::MB_W-1:1]};
            b_reg   <= b_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;
endmodule

@@ design/pmd_div.sv @@
// restoring bit-serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pmd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pmd_pkg::P_W-1:0]   n,
    input  logic [pmd_pkg::DD_W-1:0]  d,
    output logic [pmd_pkg::P_W-1:0]   quot,
    output logic                      done
);
    logic [pmd_pkg::P_W-1:0]  q_reg;
    logic [pmd_pkg::DD_W-1:0] d_reg;
    logic [pmd_pkg::DD_W-1:0] rem_reg;
    logic [pmd_pkg::DC_W-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [pmd_pkg::DD_W:0]   trial;
    logic [pmd_pkg::DD_W:0]   diff;
    logic                     fits;

    assign trial = {rem_reg, q_reg[pmd_pkg::P_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + pmd_pkg::DC_W'(1);
                if (cnt_reg == pmd_pkg::DC_W'(pmd_pkg::P_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[pmd_pkg::DD_W-1:0] : trial[pmd_pkg::DD_W-1:0];
            q_reg   <= {q_reg[pmd_pkg::P_W-2:0], fits};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

@@ design/pid_position_motor_drive.sv @@
// top level: position pid with leaky integral driving an h-bridge
// sequence: a command takes effect when accepted; an update runs through the shared serial
//   multiplier (six products) and the serial divider (two quotients) before its result is
//   valid; when dt is 0 the derivative products and quotient are skipped
// throughput: one request at a time, commands every cycle while no update is in progress;
//   a waiting result does not block acceptance, the next result waits for it
// reset: rst_n async active low clears positions, integral, time, gains, sets decay to one
`timescale 1ns / 1ps
module pid_position_motor_drive (
    input  logic       clk,
    input  logic       rst_n,
    pmd_in_if.sink     in_ch,
    pmd_out_if.source  out_ch,
    pmd_cfg_if.sink    cfg
);
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_KEEP  = 11'b00000000010,
        ST_IADD  = 11'b00000000100,
        ST_IGO   = 11'b00000001000,
        ST_IMUL  = 11'b00000010000,
        ST_IDIV  = 11'b00000100000,
        ST_PMUL  = 11'b00001000000,
        ST_DMUL1 = 11'b00010000000,
        ST_DMUL2 = 11'b00100000000,
        ST_DDIV  = 11'b01000000000,
        ST_FIN   = 11'b10000000000
    } state_t;

    localparam int CW = pmd_pkg::CNT_W;
    localparam int IW = pmd_pkg::IG_W;
    localparam int SUM_W = 66;

    state_t state_reg, state_next;

    // gains and decay
    logic [pmd_pkg::GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic [pmd_pkg::DECAY_W-1:0] decay_reg;

    // controller state
    logic [CW-1:0]              target_reg, last_reg, prev_err_reg, err_reg;
    logic [IW-1:0]              ig_reg;
    logic [pmd_pkg::TS_W-1:0]   prev_time_reg, dt_reg;
    logic [IW:0]                kept_reg;
    logic [CW:0]                de_reg;
    logic [pmd_pkg::ACC_W-1:0]  acc_reg;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          fwd_reg, rev_reg, active_reg;
    logic [pmd_pkg::DUTY_W-1:0]    duty_reg;

    // shared arithmetic units
    logic                      mul_start, div_start, mul_done, div_done;
    logic [pmd_pkg::MA_W-1:0]  mul_a;
    logic [pmd_pkg::MB_W-1:0]  mul_b;
    logic [pmd_pkg::P_W-1:0]   prod, quot;
    logic [pmd_pkg::P_W-1:0]   div_n;
    logic [pmd_pkg::DD_W-1:0]  div_d;

    pmd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    pmd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .quot  (quot),
        .done  (div_done)
    );

    // magnitudes and signs
    logic                 ig_neg, e_neg, de_neg, kp_neg, ki_neg, kd_neg;
    logic [IW-1:0]        ig_mag;
    logic [CW-1:0]        e_mag;
    logic [CW:0]          de_mag;
    logic [pmd_pkg::GAIN_W-1:0] kp_mag, ki_mag, kd_mag;

    assign ig_neg = ig_reg[IW-1];
    assign ig_mag = ig_neg ? (~ig_reg + IW'(1)) : ig_reg;
    assign e_neg  = err_reg[CW-1];
    assign e_mag  = e_neg ? (~err_reg + CW'(1)) : err_reg;
    assign de_neg = de_reg[CW];
    assign de_mag = de_neg ? (~de_reg + (CW+1)'(1)) : de_reg;
    assign kp_neg = kp_reg[pmd_pkg::GAIN_W-1];
    assign ki_neg = ki_reg[pmd_pkg::GAIN_W-1];
    assign kd_neg = kd_reg[pmd_pkg::GAIN_W-1];
    assign kp_mag = kp_neg ? (~kp_reg + pmd_pkg::GAIN_W'(1)) : kp_reg;
    assign ki_mag = ki_neg ? (~ki_reg + pmd_pkg::GAIN_W'(1)) : ki_reg;
    assign kd_mag = kd_neg ? (~kd_reg + pmd_pkg::GAIN_W'(1)) : kd_reg;

    logic in_acc, out_free;
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // result valid: cleared when taken, set when a new result is registered
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        if ((state_reg == ST_FIN) && out_free)
            out_valid_next = 1'b1;
    end

    // per-step combinational values
    logic [CW-1:0]               err_new, move_target;
    logic [IW-1:0]               kept_mag;
    logic [SUM_W-1:0]            add_v, ig_sum;
    logic [IW-1:0]               ig_sat;
    logic [pmd_pkg::ACC_W-1:0]   acc_mag, acc_shift;
    logic                        acc_neg;
    logic [pmd_pkg::DUTY_W-1:0]  duty_new;

    assign err_new = pmd_pkg::sat_cnt({target_reg[CW-1], target_reg}
                                    - {in_ch.encoder_count[CW-1], in_ch.encoder_count});
    assign move_target = pmd_pkg::sat_cnt({last_reg[CW-1], last_reg}
                                    + {in_ch.target_or_offset[CW-1], in_ch.target_or_offset});

    // decay product, trimmed back to q0
    assign kept_mag = prod[pmd_pkg::FRAC_W +: IW];

    // e*dt fits 64 bits; sum with kept value then saturate to integral width
    assign add_v  = e_neg ? (~{2'b00, prod[63:0]} + SUM_W'(1)) : {2'b00, prod[63:0]};
    assign ig_sum = {{(SUM_W-IW-1){kept_reg[IW]}}, kept_reg} + add_v;
    always_comb
    begin
        if ((&ig_sum[SUM_W-1:IW-1]) || !(|ig_sum[SUM_W-1:IW-1]))
            ig_sat = ig_sum[IW-1:0];
        else if (ig_sum[SUM_W-1])
            ig_sat = {1'b1, {(IW-1){1'b0}}};
        else
            ig_sat = {1'b0, {(IW-1){1'b1}}};
    end

    // drive value: truncate toward zero by 16 bits, clamp
    assign acc_neg   = acc_reg[pmd_pkg::ACC_W-1];
    assign acc_mag   = acc_neg ? (~acc_reg + pmd_pkg::ACC_W'(1)) : acc_reg;
    assign acc_shift = acc_mag >> pmd_pkg::FRAC_W;
    assign duty_new  = (acc_shift > pmd_pkg::ACC_W'(pmd_pkg::DRIVE_MAX))
                     ? pmd_pkg::DUTY_W'(pmd_pkg::DRIVE_MAX)
                     : acc_shift[pmd_pkg::DUTY_W-1:0];

    // sequencer: operand selection and unit starts
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_n      = prod;
        div_d      = pmd_pkg::US_PER_S;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_ch.mode == pmd_pkg::MODE_UPDATE))
                begin
                    // integral decay uses the stored integral
                    mul_start  = 1'b1;
                    mul_a      = pmd_pkg::MA_W'(ig_mag);
                    mul_b      = pmd_pkg::MB_W'(decay_reg);
                    state_next = ST_KEEP;
                end
            end
            ST_KEEP:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = pmd_pkg::MA_W'(e_mag);
                    mul_b      = dt_reg;
                    state_next = ST_IADD;
                end
            end
            ST_IADD:
            begin
                if (mul_done)
                    state_next = ST_IGO;
            end
            ST_IGO:
            begin
                mul_start  = 1'b1;
                mul_a      = pmd_pkg::MA_W'(ig_mag);
                mul_b      = ki_mag;
                state_next = ST_IMUL;
            end
            ST_IMUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_n      = prod;
                    div_d      = pmd_pkg::US_PER_S;
                    state_next = ST_IDIV;
                end
            end
            ST_IDIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = pmd_pkg::MA_W'(e_mag);
                    mul_b      = kp_mag;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                if (mul_done)
                begin
                    if (dt_reg == '0)
                        state_next = ST_FIN;
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = pmd_pkg::MA_W'(de_mag);
                        mul_b      = kd_mag;
                        state_next = ST_DMUL1;
                    end
                end
            end
            ST_DMUL1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = prod[pmd_pkg::MA_W-1:0];
                    mul_b      = pmd_pkg::US_PER_S;
                    state_next = ST_DMUL2;
                end
            end
            ST_DMUL2:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_n      = prod;
                    div_d      = dt_reg;
                    state_next = ST_DDIV;
                end
            end
            ST_DDIV:
            begin
                if (div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registers the controller keeps across requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            decay_reg     <= pmd_pkg::DECAY_ONE;
            target_reg    <= '0;
            last_reg      <= '0;
            prev_err_reg  <= '0;
            ig_reg        <= '0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            // register writes, decay above one holds at one
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    pmd_pkg::REG_KP:    kp_reg <= cfg.data;
                    pmd_pkg::REG_KI:    ki_reg <= cfg.data;
                    pmd_pkg::REG_KD:    kd_reg <= cfg.data;
                    pmd_pkg::REG_DECAY:
                    begin
                        if (cfg.data[pmd_pkg::DECAY_W-1:0] > pmd_pkg::DECAY_ONE)
                            decay_reg <= pmd_pkg::DECAY_ONE;
                        else
                            decay_reg <= cfg.data[pmd_pkg::DECAY_W-1:0];
                    end
                    default:
                    begin
                        decay_reg <= decay_reg;
                    end
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (in_ch.mode)
                            pmd_pkg::MODE_UPDATE:
                            begin
                                last_reg      <= in_ch.encoder_count;
                                prev_time_reg <= in_ch.timestamp_us;
                            end
                            pmd_pkg::MODE_TARGET:
                            begin
                                target_reg   <= in_ch.target_or_offset;
                                ig_reg       <= '0;
                                prev_err_reg <= '0;
                            end
                            pmd_pkg::MODE_MOVE:
                            begin
                                target_reg   <= move_target;
                                ig_reg       <= '0;
                                prev_err_reg <= '0;
                            end
                            pmd_pkg::MODE_RESET:
                            begin
                                target_reg   <= last_reg;
                                ig_reg       <= '0;
                                prev_err_reg <= '0;
                            end
                            default:
                            begin
                                target_reg <= target_reg;
                            end
                        endcase
                    end
                end
                ST_IADD:
                begin
                    if (mul_done)
                        ig_reg <= ig_sat;
                end
                ST_FIN:
                begin
                    if (out_free)
                        prev_err_reg <= err_reg;
                end
                default:
                begin
                    ig_reg <= ig_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    err_reg <= err_new;
                    dt_reg  <= in_ch.timestamp_us - prev_time_reg;
                end
            end
            ST_KEEP:
            begin
                if (mul_done)
                begin
                    kept_reg <= ig_neg ? (~{1'b0, kept_mag} + (IW+1)'(1)) : {1'b0, kept_mag};
                    de_reg   <= {err_reg[CW-1], err_reg} - {prev_err_reg[CW-1], prev_err_reg};
                end
            end
            ST_IDIV:
            begin
                if (div_done)
                    acc_reg <= pmd_pkg::signed_term(quot, ig_neg ^ ki_neg);
            end
            ST_PMUL:
            begin
                if (mul_done)
                    acc_reg <= acc_reg + pmd_pkg::signed_term(prod, e_neg ^ kp_neg);
            end
            ST_DDIV:
            begin
                if (div_done)
                    acc_reg <= acc_reg + pmd_pkg::signed_term(quot, de_neg ^ kd_neg);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    // zero drive means stop with the bridge in standby
                    fwd_reg    <= (duty_new != '0) && !acc_neg;
                    rev_reg    <= (duty_new != '0) && acc_neg;
                    duty_reg   <= duty_new;
                    active_reg <= (duty_new != '0);
                end
            end
            default:
            begin
                err_reg <= err_reg;
            end
        endcase
    end

    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign cfg.ready              = 1'b1;
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.dir_forward     = fwd_reg;
    assign out_ch.dir_reverse     = rev_reg;
    assign out_ch.pwm_duty        = duty_reg;
    assign out_ch.standby_release = active_reg;
    assign out_ch.motor_active    = active_reg;
endmodule

@@ design/pmd_checker.sv @@
// port-level checks for the position pid motor drive, bound to the top level
`timescale 1ns / 1ps
module pmd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [pmd_pkg::MODE_W-1:0]  in_mode,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        dir_forward,
    input logic                        dir_reverse,
    input logic [pmd_pkg::DUTY_W-1:0]  pwm_duty,
    input logic                        standby_release,
    input logic                        motor_active
);
    // one update in flight: no second request in the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == pmd_pkg::MODE_UPDATE) |=> !in_ready)
        else $error("request accepted right after an update");

    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(dir_forward && dir_reverse))
        else $error("both bridge inputs driven");

    a_active_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_active == (pwm_duty != '0))
                   && (standby_release == motor_active)
                   && (motor_active == (dir_forward || dir_reverse)))
        else $error("drive flags disagree with duty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pwm_duty))
        else $error("stalled result changed");
endmodule

bind pid_position_motor_drive pmd_checker u_pmd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_mode         (in_ch.mode),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .dir_forward     (out_ch.dir_forward),
    .dir_reverse     (out_ch.dir_reverse),
    .pwm_duty        (out_ch.pwm_duty),
    .standby_release (out_ch.standby_release),
    .motor_active    (out_ch.motor_active)
);
